### rtl/mau_pkg.sv
`default_nettype none

package mau_pkg;

    localparam int IDX_W    = 4;
    localparam int N_ELEM   = 16;
    localparam int FLD_W    = 32;
    localparam int TDATA_W  = 40;
    localparam int USER_W   = 2;
    localparam int MODE_W   = 2;
    localparam int K_W      = 2;

    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_VEC = 2'd3;

    localparam logic [IDX_W-1:0] LAST_MAT = 4'd15;
    localparam logic [IDX_W-1:0] LAST_VEC = 4'd3;
    localparam logic [K_W-1:0]   LAST_K   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_ACC,
        ST_ELEM,
        ST_OUT
    } mau_state_t;

endpackage

`default_nettype wire

### rtl/mat4_arith_unit.sv
`default_nettype none

// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+-----------------------------------------
// s_        | in        | s_tvalid/s_tready | s_tuser, s_tdata (load or compute request)
// m_        | out       | m_tvalid/m_tready | m_tdata, m_tlast (one result element)
// cfg_      | in        | cfg_valid/cfg_ready | cfg_data (op_mode)
//
// a load request writes one element of a store
// add and subtract: each of the 16 results per request passes the read, element and output steps
// matrix product: each of the 16 results sums 4 terms, each through the read, low multiply, high
// multiply, sum and accumulate steps (one read port per store); matrix times vector gives 4 results
// reset clears the mode to matrix product and the per-entry valid bits, so both stores read zero
// a stalled result holds the sequencer in its output step; the next request waits for idle

module mat4_arith_unit
    import mau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    // [3:0] element_index, [35:4] element_value, [39:36] zero
    input  wire logic [TDATA_W-1:0] s_tdata,
    // [0] compute_now, [1] operand_side
    input  wire logic [USER_W-1:0]  s_tuser,
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    // [3:0] result_index, [35:4] result_value, [39:36] zero
    output      logic [TDATA_W-1:0] m_tdata,
    output      logic               m_tlast,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [MODE_W-1:0]  cfg_data
);

    localparam int HW  = (DATA_WIDTH + 1) / 2;
    localparam int BHW = DATA_WIDTH - HW;
    localparam int LPW = DATA_WIDTH + HW + 1;
    localparam int HPW = DATA_WIDTH + BHW;
    localparam int PW  = 2 * DATA_WIDTH;
    localparam int AW  = PW + 2;
    localparam int PAD = TDATA_W - IDX_W - FLD_W;

    localparam logic signed [AW-1:0] MAX_V = {{(AW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] MIN_V = {{(AW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    mau_state_t state_reg, state_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [N_ELEM-1:0] left_vld_reg, left_vld_next;
    logic [N_ELEM-1:0] right_vld_reg, right_vld_next;

    logic [DATA_WIDTH-1:0] left_mem  [N_ELEM];
    logic [DATA_WIDTH-1:0] right_mem [N_ELEM];
    logic [DATA_WIDTH-1:0] left_rd_reg, right_rd_reg;
    logic                  left_ok_reg, right_ok_reg;

    logic signed [LPW-1:0] lo_reg, lo_next;
    logic signed [HPW-1:0] hi_reg, hi_next;
    logic signed [PW-1:0]  term_reg, term_next;
    logic signed [AW-1:0]  acc_reg, acc_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [DATA_WIDTH-1:0] in_value;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      left_addr, right_addr;
    logic                  s_acc, ld_left, ld_right, start;
    logic                  elem_mode, last_pos, out_free, out_load;
    logic signed [DATA_WIDTH-1:0] op_a, op_b;
    logic signed [PW-1:0]  hi_ext, lo_ext, full;
    logic signed [AW-1:0]  a_ext, b_ext, ew;
    logic [DATA_WIDTH-1:0] sat_val;
    logic [FLD_W-1:0]      out_value;

    generate
        if (DATA_WIDTH <= FLD_W) begin : g_in_narrow
            assign in_value = s_tdata[IDX_W +: DATA_WIDTH];
        end else begin : g_in_wide
            assign in_value = {{(DATA_WIDTH-FLD_W){1'b0}}, s_tdata[IDX_W +: FLD_W]};
        end
        if (DATA_WIDTH >= FLD_W) begin : g_out_narrow
            assign out_value = sat_val[FLD_W-1:0];
        end else begin : g_out_wide
            assign out_value = {{(FLD_W-DATA_WIDTH){1'b0}}, sat_val};
        end
    endgenerate

    assign wr_addr   = s_tdata[IDX_W-1:0];
    assign s_acc     = s_tvalid && s_tready;
    assign ld_left   = s_acc && !s_tuser[0] && !s_tuser[1];
    assign ld_right  = s_acc && !s_tuser[0] && s_tuser[1];
    assign start     = s_acc && s_tuser[0];
    assign elem_mode = (mode_reg == MODE_ADD) || (mode_reg == MODE_SUB);
    assign last_pos  = (mode_reg == MODE_VEC) ? (pos_reg == LAST_VEC) : (pos_reg == LAST_MAT);
    assign out_free  = !m_tvalid_reg || m_tready;

    // a product element (c,r) takes left (k,r) and right (c,k); the vector is column zero of the right store
    always_comb begin
        if (elem_mode) begin
            left_addr  = pos_reg;
            right_addr = pos_reg;
        end else begin
            left_addr  = {k_reg, pos_reg[1:0]};
            right_addr = {pos_reg[3:2], k_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_left) begin
            left_mem[wr_addr] <= in_value;
        end
        if (ld_right) begin
            right_mem[wr_addr] <= in_value;
        end
        left_rd_reg  <= left_mem[left_addr];
        right_rd_reg <= right_mem[right_addr];
        left_ok_reg  <= left_vld_reg[left_addr];
        right_ok_reg <= right_vld_reg[right_addr];
    end

    assign op_a = left_ok_reg  ? left_rd_reg  : '0;
    assign op_b = right_ok_reg ? right_rd_reg : '0;

    // datapath
    always_comb begin
        lo_next   = op_a * $signed({1'b0, op_b[HW-1:0]});
        hi_next   = op_a * $signed(op_b[DATA_WIDTH-1:HW]);
        hi_ext    = {{HW{hi_reg[HPW-1]}}, hi_reg};
        lo_ext    = {{(PW-LPW){lo_reg[LPW-1]}}, lo_reg};
        full      = (hi_ext <<< HW) + lo_ext;
        term_next = full >>> FRAC_BITS;
        a_ext     = {{(AW-DATA_WIDTH){op_a[DATA_WIDTH-1]}}, op_a};
        b_ext     = {{(AW-DATA_WIDTH){op_b[DATA_WIDTH-1]}}, op_b};
        ew        = (mode_reg == MODE_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
        if (acc_reg > MAX_V) begin
            sat_val = MAX_V[DATA_WIDTH-1:0];
        end else if (acc_reg < MIN_V) begin
            sat_val = MIN_V[DATA_WIDTH-1:0];
        end else begin
            sat_val = acc_reg[DATA_WIDTH-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = elem_mode ? ST_ELEM : ST_MUL_LO;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ACC;
            ST_ACC: begin
                state_next = (k_reg == LAST_K) ? ST_OUT : ST_READ;
            end
            ST_ELEM:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = last_pos ? ST_IDLE : ST_READ;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and next register values
    always_comb begin
        s_tready      = 1'b0;
        out_load      = 1'b0;
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        left_vld_next = left_vld_reg;
        right_vld_next = right_vld_reg;
        if (cfg_valid) begin
            mode_next = cfg_data;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (ld_left) begin
                    left_vld_next[wr_addr] = 1'b1;
                end
                if (ld_right) begin
                    right_vld_next[wr_addr] = 1'b1;
                end
                if (start) begin
                    pos_next = '0;
                    k_next   = '0;
                    acc_next = '0;
                end
            end
            ST_ACC: begin
                acc_next = acc_reg + {{(AW-PW){term_reg[PW-1]}}, term_reg};
                k_next   = k_reg + 1'b1;
            end
            ST_ELEM: begin
                acc_next = ew;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    k_next   = '0;
                    acc_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{PAD{1'b0}}, out_value, pos_reg};
            m_tlast_next  = last_pos;
        end else begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
            m_tdata_next  = m_tdata_reg;
            m_tlast_next  = m_tlast_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_MAT;
            pos_reg       <= '0;
            k_reg         <= '0;
            left_vld_reg  <= '0;
            right_vld_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            left_vld_reg  <= left_vld_next;
            right_vld_reg <= right_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL_LO) begin
            lo_reg <= lo_next;
        end
        if (state_reg == ST_MUL_HI) begin
            hi_reg <= hi_next;
        end
        if (state_reg == ST_SUM) begin
            term_reg <= term_next;
        end
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] == LAST_VEC
                                   || m_tdata[IDX_W-1:0] == LAST_MAT))
        else $error("last result at a middle index");

    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && k_reg == '0) |-> (acc_reg == '0))
        else $error("accumulator not cleared at start of a result");

    a_four_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && state_next == ST_OUT) |-> (k_reg == LAST_K))
        else $error("result issued before four terms");

    a_idle_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("result appeared while idle");

    a_vec_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && mode_reg == MODE_VEC) |-> (right_addr[3:2] == 2'b00))
        else $error("vector read outside right column zero");

endmodule

`default_nettype wire

### dv/mat4_arith_unit_tb.sv
module mat4_arith_unit_tb;
    import mau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC        = 16;
    localparam int     STALL_LIMIT = 4000;
    localparam longint SAT_MAX     = 64'sd2147483647;
    localparam longint SAT_MIN     = -64'sd2147483648;
    localparam logic [MODE_W-1:0] MODE_CYCLE [4] = '{MODE_ADD, MODE_SUB, MODE_MAT, MODE_VEC};

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [FLD_W-1:0] value;
        logic             last;
    } result_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic [USER_W-1:0]  s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [MODE_W-1:0]  cfg_data  = MODE_MAT;

    // shadow copies of the block's stores and mode
    logic signed [FLD_W-1:0] left_store  [N_ELEM];
    logic signed [FLD_W-1:0] right_store [N_ELEM];
    logic [MODE_W-1:0]       mode_shadow = MODE_MAT;

    result_t expected_results [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      quiet_cycles   = 0;
    int      hold_request   = 0;
    int      stall_left     = 0;
    bit      idling_on      = 1'b1;

    mat4_arith_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint fx_term(input logic signed [FLD_W-1:0] a,
                                       input logic signed [FLD_W-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> FRAC;
    endfunction

    function automatic logic [FLD_W-1:0] sat32(input longint v);
        if (v > SAT_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            return 32'h8000_0000;
        end
        return v[FLD_W-1:0];
    endfunction

    function automatic logic [FLD_W-1:0] rand_value(input logic small_only);
        // small values stay within +-8.0 so products do not saturate
        if (small_only) begin
            return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        end
        case ($urandom_range(0, 7))
            0: begin
                return 32'h7FFF_FFFF;
            end
            1: begin
                return 32'h8000_0000;
            end
            2: begin
                return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
            3, 4: begin
                return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic predict_results();
        longint acc;
        int     p;
        if (mode_shadow == MODE_VEC) begin
            for (int r = 0; r < 4; r++) begin
                acc = 0;
                for (int c = 0; c < 4; c++) begin
                    acc += fx_term(left_store[c*4+r], right_store[c]);
                end
                expected_results.push_back('{IDX_W'(r), sat32(acc), IDX_W'(r) == LAST_VEC});
            end
        end else begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    p = c * 4 + r;
                    case (mode_shadow)
                        MODE_ADD: begin
                            acc = longint'(left_store[p]) + longint'(right_store[p]);
                        end
                        MODE_SUB: begin
                            acc = longint'(left_store[p]) - longint'(right_store[p]);
                        end
                        default: begin
                            acc = 0;
                            for (int k = 0; k < 4; k++) begin
                                acc += fx_term(left_store[k*4+r], right_store[c*4+k]);
                            end
                        end
                    endcase
                    expected_results.push_back('{IDX_W'(p), sat32(acc), IDX_W'(p) == LAST_MAT});
                end
            end
        end
    endtask

    task automatic issue_request(input logic compute, input logic side,
                                 input logic [IDX_W-1:0] idx, input logic [FLD_W-1:0] value);
        int gap;
        gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= {side, compute};
        s_tdata  <= {{(TDATA_W-FLD_W-IDX_W){1'b0}}, value, idx};
        do @(posedge aclk); while (!s_tready);
        if (compute) begin
            predict_results();
        end else if (side) begin
            right_store[idx] = value;
        end else begin
            left_store[idx] = value;
        end
    endtask

    task automatic load_random(input logic small_only);
        issue_request(1'b0, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)),
                      rand_value(small_only));
    endtask

    task automatic compute_random();
        // side, index and value ride along and must be ignored
        issue_request(1'b1, 1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)), $urandom);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge aclk); while (!cfg_ready);
        mode_shadow = m;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        // default mode is matrix product over cleared stores
        compute_random();
        wait_idle();
    endtask

    task automatic test_directed_cases();
        issue_request(1'b0, 1'b0, 4'd0,  32'h7FFF_FFFF);
        issue_request(1'b0, 1'b1, 4'd0,  32'h7FFF_FFFF);
        issue_request(1'b0, 1'b0, 4'd1,  32'h8000_0000);
        issue_request(1'b0, 1'b1, 4'd1,  32'h8000_0000);
        issue_request(1'b0, 1'b0, 4'd15, 32'hFFFF_FFFF);
        issue_request(1'b0, 1'b1, 4'd15, 32'h0000_0001);
        wait_idle();
        write_mode(MODE_ADD);
        issue_request(1'b1, 1'b0, 4'd0, 32'h0);
        wait_idle();
        write_mode(MODE_SUB);
        issue_request(1'b0, 1'b1, 4'd1, 32'h7FFF_FFFF);
        issue_request(1'b1, 1'b0, 4'd0, 32'h0);
        wait_idle();
        // large products saturate, minus one times one truncates downwards
        write_mode(MODE_MAT);
        issue_request(1'b1, 1'b1, 4'd15, 32'h1234_5678);
        wait_idle();
        write_mode(MODE_VEC);
        issue_request(1'b0, 1'b1, 4'd2, 32'h0001_8000);
        issue_request(1'b0, 1'b0, 4'd10, 32'hFFFE_8000);
        issue_request(1'b1, 1'b1, 4'd3, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [MODE_W-1:0] m;
        logic              small_only;
        for (int ph = 0; ph < 12; ph++) begin
            m = MODE_CYCLE[ph < 4 ? ph : $urandom_range(0, 3)];
            write_mode(m);
            small_only = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 2) == 0) begin
                // fill both stores completely before computing
                for (int i = 0; i < 2 * N_ELEM; i++) begin
                    issue_request(1'b0, 1'(i / N_ELEM), IDX_W'(i % N_ELEM),
                                  rand_value(small_only));
                end
            end else begin
                for (int i = 0; i < 22; i++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        compute_random();
                    end else begin
                        load_random(small_only);
                    end
                end
            end
            compute_random();
            wait_idle();
        end
    endtask

    task automatic test_output_backpressure();
        write_mode(MODE_ADD);
        @(posedge aclk);
        hold_request = 300;
        for (int i = 0; i < 5; i++) begin
            load_random(1'b0);
            load_random(1'b0);
            compute_random();
        end
        wait_idle();
    endtask

    task automatic test_steady_stream();
        idling_on = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            write_mode(MODE_CYCLE[3 - ph]);
            for (int i = 0; i < 20; i++) begin
                if ($urandom_range(0, 6) == 0) begin
                    compute_random();
                end else begin
                    load_random(1'($urandom_range(0, 1)));
                end
            end
            compute_random();
            wait_idle();
        end
    endtask

    // result receiver with random stalls and one long hold on request
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[IDX_W-1:0], m_tdata[IDX_W+FLD_W-1:IDX_W], m_tlast};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: index %0d value %h last %b",
                             got.idx, got.value, got.last);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.idx !== want.idx || got.value !== want.value || got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d: expected %0d %h %b, got %0d %h %b",
                                 results_seen, want.idx, want.value, want.last,
                                 got.idx, got.value, got.last);
                    end
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("mat4_arith_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < N_ELEM; i++) begin
            left_store[i]  = '0;
            right_store[i] = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_directed_cases();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("mat4_arith_unit: match");
        end else begin
            $display("mat4_arith_unit: mismatch");
        end
        $finish;
    end

endmodule
